### hdl/plic_pkg.sv
// Shared constants, codes and types of the piecewise linear interpolator.
package plic_pkg;

    localparam int MAX_POINTS = 32;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * DATA_W + 1;
    localparam int STEP_W     = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_FEW   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

### hdl/plic_cell.sv
// One breakpoint cell of the sorted table; shifts up from its neighbour on insert.
module plic_cell import plic_pkg::*;
(
    input  logic                     clk,
    input  logic                     ins_en,
    input  logic                     is_first,
    input  logic                     cell_valid,
    input  logic signed [DATA_W-1:0] new_x,
    input  logic signed [DATA_W-1:0] new_y,
    input  logic signed [DATA_W-1:0] prev_x,
    input  logic signed [DATA_W-1:0] prev_y,
    input  logic                     prev_less,
    output logic signed [DATA_W-1:0] cell_x,
    output logic signed [DATA_W-1:0] cell_y,
    output logic                     less,
    output logic                     equal
);

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;

    // compare held point against the item abscissa
    assign less   = cell_valid && (x_reg < new_x);
    assign equal  = cell_valid && (x_reg == new_x);
    assign cell_x = x_reg;
    assign cell_y = y_reg;

    // keep smaller points, place the new one at the boundary, shift the rest up
    always_ff @(posedge clk)
    begin
        if (ins_en && !less)
        begin
            if (is_first || prev_less)
            begin
                x_reg <= new_x;
                y_reg <= new_y;
            end
            else
            begin
                x_reg <= prev_x;
                y_reg <= prev_y;
            end
        end
    end

endmodule

### hdl/plic_muldiv.sv
// Bit-serial multiply of two magnitudes followed by restoring division.
module plic_muldiv import plic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIFF_W-1:0]        mag_a,
    input  logic [DIFF_W-1:0]        mag_b,
    input  logic [DIFF_W-1:0]        divisor,
    output logic                     done,
    output logic [PROD_W-1:0]        quotient
);

    logic                busy_reg;
    logic                div_phase_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   mcand_reg;
    logic [DIFF_W-1:0]   mplier_reg;
    logic [DIFF_W-1:0]   den_reg;
    logic [DIFF_W-1:0]   rem_reg;
    logic                done_reg;
    logic [DIFF_W:0]     trial;
    logic                fits;

    assign trial    = {rem_reg, acc_reg[PROD_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = acc_reg;

    // control: multiply phase, then divide phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            div_phase_reg <= 1'b0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg      <= 1'b1;
                div_phase_reg <= 1'b0;
                step_reg      <= '0;
            end
            else if (busy_reg)
            begin
                if (!div_phase_reg && step_reg == STEP_W'(DIFF_W - 1))
                begin
                    div_phase_reg <= 1'b1;
                    step_reg      <= '0;
                end
                else if (div_phase_reg && step_reg == STEP_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // datapath: shift-add product, then quotient shifts into the accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(mag_a);
            mplier_reg <= mag_b;
            den_reg    <= divisor;
            rem_reg    <= '0;
        end
        else if (busy_reg && !div_phase_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[DIFF_W-1:1]};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIFF_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DIFF_W-1:0];
            end
            acc_reg <= {acc_reg[PROD_W-2:0], fits};
        end
    end

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held too long");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("start while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg)) else $error("done without work");

endmodule

### hdl/piecewise_linear_interpolator.sv
// Top level: sorted breakpoint cell row, segment pick, serial interpolation.
//  channel | signals                          | direction
//  input   | in_valid, in_stall, op, x_value, y_value | in (stall out)
//  output  | out_valid, out_stall, status, result_y, point_count | out (stall in)
// Add, clear and short queries pass through the execute and done states before their
// result is held in the output register.
// A query also runs the start and wait states, whose length is set by the 33 multiply
// steps and 65 divide steps of the bit-serial unit.
// Reset empties the table at once; no clearing pass.
// A new word is taken as soon as the previous item has moved to the output register.
module piecewise_linear_interpolator import plic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] y_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] result_y,
    output logic [CNT_W-1:0]         point_count
);

    state_t                   state_reg;
    logic [1:0]               op_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic [CNT_W-1:0]         count_reg;
    status_t                  stat_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic signed [DATA_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic signed [DATA_W-1:0] out_y_reg;
    logic [CNT_W-1:0]         out_count_reg;

    logic signed [DATA_W-1:0] cx [MAX_POINTS];
    logic signed [DATA_W-1:0] cy [MAX_POINTS];
    logic [MAX_POINTS-1:0]    less;
    logic [MAX_POINTS-1:0]    equal;
    logic [MAX_POINTS-1:0]    valid;
    logic [MAX_POINTS-1:0]    last;
    logic                     ins_en;
    logic                     dup;
    logic                     full;
    logic signed [DATA_W-1:0] sel_x0, sel_y0, sel_x1, sel_y1;

    logic signed [DIFF_W-1:0] num, dy, den;
    logic [DIFF_W-1:0]        mag_num, mag_dy;
    logic                     neg;
    logic                     md_start;
    logic                     md_done;
    logic [PROD_W-1:0]        md_q;
    logic signed [DIFF_W+1:0] qs;
    logic signed [DIFF_W+1:0] total;
    logic signed [DATA_W-1:0] interp;
    logic                     loadable;

    // per-cell occupancy flags
    always_comb
    begin
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            valid[k] = CNT_W'(k) < count_reg;
            last[k]  = CNT_W'(k + 1) == count_reg;
        end
    end

    // cell row
    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        plic_cell u_cell (
            .clk        (clk),
            .ins_en     (ins_en),
            .is_first   (k == 0),
            .cell_valid (valid[k]),
            .new_x      (x_reg),
            .new_y      (y_reg),
            .prev_x     ((k == 0) ? x_reg : cx[(k == 0) ? 0 : k - 1]),
            .prev_y     ((k == 0) ? y_reg : cy[(k == 0) ? 0 : k - 1]),
            .prev_less  ((k == 0) ? 1'b0 : less[(k == 0) ? 0 : k - 1]),
            .cell_x     (cx[k]),
            .cell_y     (cy[k]),
            .less       (less[k]),
            .equal      (equal[k])
        );
    end

    assign dup  = |equal;
    assign full = count_reg == CNT_W'(MAX_POINTS);
    assign ins_en = (state_reg == S_EXEC) && (op_reg == OP_ADD) && !dup && !full;

    // pick the segment: lower point below the abscissa, upper point at or above it, clipped to the end segments
    always_comb
    begin
        sel_x0 = '0;
        sel_y0 = '0;
        sel_x1 = '0;
        sel_y1 = '0;
        for (int k = 0; k < MAX_POINTS - 1; k++)
        begin
            if (valid[k+1] && (k == 0 || less[k]) && (last[k+1] || !less[k+1]))
            begin
                sel_x0 = sel_x0 | cx[k];
                sel_y0 = sel_y0 | cy[k];
                sel_x1 = sel_x1 | cx[k+1];
                sel_y1 = sel_y1 | cy[k+1];
            end
        end
    end

    // segment differences and magnitudes
    assign num     = DIFF_W'(x_reg) - DIFF_W'(x0_reg);
    assign dy      = DIFF_W'(y1_reg) - DIFF_W'(y0_reg);
    assign den     = DIFF_W'(x1_reg) - DIFF_W'(x0_reg);
    assign mag_num = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign mag_dy  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    assign neg     = num[DIFF_W-1] != dy[DIFF_W-1];
    assign md_start = state_reg == S_START;

    plic_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .mag_a    (mag_num),
        .mag_b    (mag_dy),
        .divisor  (den),
        .done     (md_done),
        .quotient (md_q)
    );

    // signed quotient, offset and saturation
    always_comb
    begin
        qs    = neg ? -$signed({1'b0, md_q[DIFF_W:0]}) : $signed({1'b0, md_q[DIFF_W:0]});
        total = (DIFF_W+2)'(y0_reg) + qs;
        if (md_q > (PROD_W'(1) << (DIFF_W)))
        begin
            interp = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (total > (DIFF_W+2)'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
        begin
            interp = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (total < (DIFF_W+2)'(signed'({1'b1, {(DATA_W-1){1'b0}}})))
        begin
            interp = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            interp = total[DATA_W-1:0];
        end
    end

    assign loadable = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != S_IDLE;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (ins_en)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                state_reg <= S_START;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (md_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (loadable)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item payload, status and segment end points
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op;
            x_reg  <= x_value;
            y_reg  <= y_value;
        end
        if (state_reg == S_EXEC)
        begin
            res_reg <= '0;
            x0_reg  <= sel_x0;
            y0_reg  <= sel_y0;
            x1_reg  <= sel_x1;
            y1_reg  <= sel_y1;
            case (op_reg)
                OP_ADD:   stat_reg <= dup ? ST_DUP : (full ? ST_FULL : ST_OK);
                OP_QUERY: stat_reg <= (count_reg < CNT_W'(2)) ? ST_FEW : ST_OK;
                default:  stat_reg <= ST_OK;
            endcase
        end
        if (state_reg == S_WAIT && md_done)
        begin
            res_reg <= interp;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && loadable)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && loadable)
        begin
            out_status_reg <= stat_reg;
            out_y_reg      <= res_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_y    = out_y_reg;
    assign point_count = out_count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> count_reg == $past(count_reg) + 1'b1) else $error("insert lost count");
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE)) else $error("stray word");
    a_start_query: assert property (@(posedge clk) disable iff (!rst_n)
        md_start |-> count_reg >= CNT_W'(2)) else $error("query with short table");

endmodule
